### rtl/core/wblc_pkg.sv
// Shared constants and types of the write-back LRU block cache core.
package wblc_pkg;

    // Default geometry
    localparam int WAYS_DEF       = 8;
    localparam int NUM_BLOCKS_DEF = 2048;
    localparam int BLK_W_DEF      = $clog2(NUM_BLOCKS_DEF);
    localparam int WAY_W_DEF      = $clog2(WAYS_DEF);

    // Access kinds carried on the mode bit
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

endpackage

### rtl/core/wblc_if.sv
// Request and response channel interfaces of the block cache core.
interface wblc_req_if #(
    parameter int BLK_W = wblc_pkg::BLK_W_DEF
);
    logic             valid;
    logic             ready;
    logic             mode;
    logic [BLK_W-1:0] block;

    modport source (output valid, output mode, output block, input ready);
    modport sink   (input valid, input mode, input block, output ready);
endinterface

interface wblc_rsp_if #(
    parameter int BLK_W = wblc_pkg::BLK_W_DEF,
    parameter int WAY_W = wblc_pkg::WAY_W_DEF
);
    logic             valid;
    logic             ready;
    logic             hit;
    logic [WAY_W-1:0] way;
    logic             fetch;
    logic             writeback;
    logic [BLK_W-1:0] victim_block;

    modport source (output valid, output hit, output way, output fetch,
                    output writeback, output victim_block, input ready);
    modport sink   (input valid, input hit, input way, input fetch,
                    input writeback, input victim_block, output ready);
endinterface

### rtl/core/write_back_lru_block_cache_core.sv
// Top level: tag scan, victim choice and LRU update of a fully associative block cache.
//
//  Channel  | Dir | Handshake     | Word contents
//  ---------+-----+---------------+-----------------------------------------------
//  i_req    | in  | valid / ready | mode (0 read, 1 write), block
//  o_rsp    | out | valid / ready | hit, way, fetch, writeback, victim_block
//
//  An access passes an accept state, then a scan in which the single tag comparator walks
//  the tag RAM one way per cycle behind its registered read, then an update state.
//  i_rst_n is synchronous, active low: it clears valid and dirty bits, sets each rank to
//  its way index and empties the response register. The tag RAM is not cleared.
//  A stalled response holds in its register; the update waits for it to leave.
module write_back_lru_block_cache_core #(
    parameter int WAYS       = wblc_pkg::WAYS_DEF,
    parameter int NUM_BLOCKS = wblc_pkg::NUM_BLOCKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wblc_req_if.sink    i_req,
    wblc_rsp_if.source  o_rsp
);

    localparam int BLK_W = $clog2(NUM_BLOCKS);
    localparam int WAY_W = $clog2(WAYS);

    localparam logic [WAY_W:0]   WAYS_CNT = (WAY_W + 1)'(WAYS);
    localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);
    localparam logic [WAY_W-1:0] TOP_RANK = WAY_W'(WAYS - 1);

    // Sequencer
    wblc_pkg::t_state r_state, n_state;
    logic [WAY_W:0]   r_idx, n_idx;
    logic             r_cmp_vld, n_cmp_vld;
    logic [WAY_W-1:0] r_cmp_idx;

    // Captured request
    logic             r_mode;
    logic [BLK_W-1:0] r_blk;

    // Scan findings
    logic             r_hit;
    logic [WAY_W-1:0] r_hit_way;
    logic             r_inv_found;
    logic [WAY_W-1:0] r_inv_way;
    logic [WAY_W-1:0] r_lru_way;
    logic [BLK_W-1:0] r_lru_tag;

    // Way metadata
    logic [WAYS-1:0]  r_valid;
    logic [WAYS-1:0]  r_dirty;
    logic [WAY_W-1:0] r_rank [WAYS];

    // Response register
    logic             r_out_vld;
    logic             r_out_hit;
    logic [WAY_W-1:0] r_out_way;
    logic             r_out_fetch;
    logic             r_out_wb;
    logic [BLK_W-1:0] r_out_victim;

    // Datapath wires
    logic             issue;
    logic             rd_en;
    logic             upd_fire;
    logic             out_free;
    logic             accept;
    logic [BLK_W-1:0] ram_rdata;
    logic             cmp_valid;
    logic             cmp_match;
    logic             cmp_lru;
    logic [WAY_W-1:0] sel_way;
    logic [WAY_W-1:0] sel_rank;
    logic             sel_wb;

    // Tag store
    wblc_ram #(
        .WIDTH (BLK_W),
        .DEPTH (WAYS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (upd_fire && !r_hit),
        .i_waddr (sel_way),
        .i_wdata (r_blk),
        .i_re    (rd_en),
        .i_raddr (r_idx[WAY_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_out_vld || o_rsp.ready;
    assign issue    = r_idx < WAYS_CNT;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            wblc_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = wblc_pkg::ST_SCAN;
                end
            end
            wblc_pkg::ST_SCAN: begin
                if (r_cmp_vld && r_cmp_idx == LAST_WAY) begin
                    n_state = wblc_pkg::ST_UPDATE;
                end
            end
            wblc_pkg::ST_UPDATE: begin
                if (out_free) begin
                    n_state = wblc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wblc_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        i_req.ready = 1'b0;
        rd_en       = 1'b0;
        upd_fire    = 1'b0;
        case (r_state)
            wblc_pkg::ST_IDLE: begin
                i_req.ready = 1'b1;
            end
            wblc_pkg::ST_SCAN: begin
                rd_en = issue;
            end
            wblc_pkg::ST_UPDATE: begin
                upd_fire = out_free;
            end
            default: begin
                i_req.ready = 1'b0;
            end
        endcase
    end

    assign accept = i_req.valid && i_req.ready;

    // Scan counter: issue one tag read per cycle, compare it in the next cycle
    always_comb begin
        n_idx     = r_idx;
        n_cmp_vld = 1'b0;
        if (accept) begin
            n_idx = '0;
        end else if (rd_en) begin
            n_idx     = r_idx + 1'b1;
            n_cmp_vld = 1'b1;
        end
    end

    // Shared comparator on the way just read
    assign cmp_valid = r_valid[r_cmp_idx];
    assign cmp_match = r_cmp_vld && cmp_valid && (ram_rdata == r_blk);
    assign cmp_lru   = r_cmp_vld && (r_rank[r_cmp_idx] == '0);

    // Pick the way: hit, else lowest invalid, else least recently used
    always_comb begin
        if (r_hit) begin
            sel_way = r_hit_way;
        end else if (r_inv_found) begin
            sel_way = r_inv_way;
        end else begin
            sel_way = r_lru_way;
        end
    end

    assign sel_rank = r_rank[sel_way];
    assign sel_wb   = !r_hit && !r_inv_found && r_dirty[r_lru_way];

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= wblc_pkg::ST_IDLE;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    // Capture the request and track scan findings
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_idx[WAY_W-1:0];
        if (accept) begin
            r_mode      <= i_req.mode;
            r_blk       <= i_req.block;
            r_hit       <= 1'b0;
            r_inv_found <= 1'b0;
        end else begin
            if (cmp_match && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_way <= r_cmp_idx;
            end
            if (r_cmp_vld && !cmp_valid && !r_inv_found) begin
                r_inv_found <= 1'b1;
                r_inv_way   <= r_cmp_idx;
            end
            if (cmp_lru) begin
                r_lru_way <= r_cmp_idx;
                r_lru_tag <= ram_rdata;
            end
        end
    end

    // Update valid, dirty and recency ranks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
            for (int i = 0; i < WAYS; i++) begin
                r_rank[i] <= WAY_W'(i);
            end
        end else if (upd_fire) begin
            r_valid[sel_way] <= 1'b1;
            if (r_hit) begin
                r_dirty[sel_way] <= r_dirty[sel_way] || (r_mode == wblc_pkg::MODE_WRITE);
            end else begin
                r_dirty[sel_way] <= (r_mode == wblc_pkg::MODE_WRITE);
            end
            for (int i = 0; i < WAYS; i++) begin
                if (WAY_W'(i) == sel_way) begin
                    r_rank[i] <= TOP_RANK;
                end else if (r_rank[i] > sel_rank) begin
                    r_rank[i] <= r_rank[i] - 1'b1;
                end
            end
        end
    end

    // Response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (upd_fire) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // Response word
    always_ff @(posedge i_clk) begin
        if (upd_fire) begin
            r_out_hit    <= r_hit;
            r_out_way    <= sel_way;
            r_out_fetch  <= !r_hit && (r_mode == wblc_pkg::MODE_READ);
            r_out_wb     <= sel_wb;
            r_out_victim <= sel_wb ? r_lru_tag : '0;
        end
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.hit          = r_out_hit;
    assign o_rsp.way          = r_out_way;
    assign o_rsp.fetch        = r_out_fetch;
    assign o_rsp.writeback    = r_out_wb;
    assign o_rsp.victim_block = r_out_victim;

endmodule

### rtl/core/wblc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wblc_ram #(
    parameter  int WIDTH = wblc_pkg::BLK_W_DEF,
    parameter  int DEPTH = wblc_pkg::WAYS_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/wblc_checker.sv
// Port-level checker for the block cache core, bound to the top level.
module wblc_checker #(
    parameter int BLK_W = wblc_pkg::BLK_W_DEF
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_req_valid,
    input logic             i_req_ready,
    input logic             i_rsp_valid,
    input logic             i_rsp_ready,
    input logic             i_rsp_hit,
    input logic             i_rsp_fetch,
    input logic             i_rsp_writeback,
    input logic [BLK_W-1:0] i_rsp_victim
);

    // Accepting a word starts a scan, so ready must drop
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request ready stayed high after an accept");

    // A hit neither fetches nor evicts
    a_hit_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_hit |-> !i_rsp_fetch && !i_rsp_writeback && i_rsp_victim == '0)
        else $error("hit response carries fetch or writeback");

    // Victim block is zero unless a dirty way is written back
    a_victim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_writeback |-> i_rsp_victim == '0)
        else $error("victim block set without writeback");

    // A stalled response stays valid and holds its hit and victim fields
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_hit)
            && $stable(i_rsp_victim))
        else $error("stalled response changed");

endmodule

bind write_back_lru_block_cache_core wblc_checker #(
    .BLK_W (BLK_W)
) u_wblc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_hit       (o_rsp.hit),
    .i_rsp_fetch     (o_rsp.fetch),
    .i_rsp_writeback (o_rsp.writeback),
    .i_rsp_victim    (o_rsp.victim_block)
);
